### rtl/adcpwm_pkg.sv
// Shared constants, queue entry type and segment decoder for the duty/display block.
package adcpwm_pkg;

  localparam logic OP_CONV = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int SAMPLE_W = 10;
  localparam int DUTY_W   = 7;
  localparam int CMP_W    = 17;
  localparam int PERIOD_W = 16;
  localparam int SEG_W    = 7;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd19999;
  localparam logic [DUTY_W-1:0]   DUTY_RESET   = 7'd50;
  localparam logic [DUTY_W-1:0]   DUTY_FULL    = 7'd100;
  localparam logic [SEG_W-1:0]    SEG_FULL     = 7'h5C;
  localparam logic [SEG_W-1:0]    SEG_BLANK    = 7'h00;

  // floor(2^29 / 100); estimate is at most one low, fixed up afterwards
  localparam logic [22:0] CMP_RECIP = 23'd5368709;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic                is_tick;
    logic [SAMPLE_W-1:0] mean;
  } q_entry_t;

  function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

### rtl/adcpwm_if.sv
// Channel interfaces: input items, result items and the period register write.
interface adcpwm_in_if import adcpwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SAMPLE_W-1:0] sample_a;
  logic [SAMPLE_W-1:0] sample_b;
  logic [SAMPLE_W-1:0] sample_c;
  logic [SAMPLE_W-1:0] sample_d;

  modport source (output valid, opcode, sample_a, sample_b, sample_c, sample_d, input ready);
  modport sink   (input valid, opcode, sample_a, sample_b, sample_c, sample_d, output ready);
endinterface

interface adcpwm_out_if import adcpwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_percent;
  logic [CMP_W-1:0]  compare_value;
  logic              high_digit_on;
  logic [SEG_W-1:0]  segments;
  logic              full_led;

  modport source (output valid, duty_percent, compare_value, high_digit_on, segments,
                  full_led, input ready);
  modport sink   (input valid, duty_percent, compare_value, high_digit_on, segments,
                  full_led, output ready);
endinterface

interface adcpwm_cfg_if import adcpwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/adcpwm_front.sv
// Front end: accepts items, decodes the opcode and forms the rounded sample mean.
module adcpwm_front import adcpwm_pkg::*; (
  adcpwm_in_if.sink item,
  input  logic      q_full,
  output logic      q_push,
  output q_entry_t  q_entry
);

  logic [SAMPLE_W+1:0] sum;

  assign item.ready = !q_full;
  assign q_push     = item.valid && !q_full;

  // four samples plus the rounding half, then divide by four
  assign sum = {2'b00, item.sample_a} + {2'b00, item.sample_b}
             + {2'b00, item.sample_c} + {2'b00, item.sample_d} + 12'd2;

  assign q_entry.is_tick = (item.opcode == OP_TICK);
  assign q_entry.mean    = sum[SAMPLE_W+1:2];

endmodule

### rtl/adcpwm_queue.sv
// Short FIFO of decoded items between front and back end.
module adcpwm_queue import adcpwm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_entry,
  output logic     empty
);

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/adcpwm_back.sv
// Back end: duty update, compare value by reciprocal, display decode, result register.
module adcpwm_back import adcpwm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  adcpwm_cfg_if.sink    cfg,
  input  logic          q_empty,
  input  q_entry_t      q_entry,
  output logic          q_pop,
  adcpwm_out_if.source  result
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DUTY_EST = 3'd1;
  localparam logic [2:0] S_DUTY_FIX = 3'd2;
  localparam logic [2:0] S_CMP_MUL  = 3'd3;
  localparam logic [2:0] S_CMP_EST  = 3'd4;
  localparam logic [2:0] S_CMP_FIX  = 3'd5;

  logic [2:0]          state;
  logic [PERIOD_W-1:0] period;
  logic [DUTY_W-1:0]   duty_value;
  logic                digit_phase;
  logic                is_tick;
  logic [16:0]         x;
  logic [DUTY_W-1:0]   dq;
  logic [22:0]         y;
  logic [CMP_W-1:0]    cq;

  logic                out_valid;
  logic [DUTY_W-1:0]   out_duty;
  logic [CMP_W-1:0]    out_cmp;
  logic                out_high;
  logic [SEG_W-1:0]    out_seg;
  logic                out_full;

  logic [16:0]         x_next;
  logic [26:0]         x_rcp;
  logic [16:0]         dq_mul;
  logic [16:0]         dq_rem;
  logic [DUTY_W-1:0]   duty_fix;
  logic [CMP_W-1:0]    counts;
  logic [23:0]         y_prod;
  logic [45:0]         c_prod;
  logic [22:0]         cq_mul;
  logic [22:0]         cq_rem;
  logic [CMP_W-1:0]    cmp_fix;
  logic [14:0]         tens_prod;
  logic [3:0]          tens;
  logic [DUTY_W-1:0]   tens_x10;
  logic [DUTY_W-1:0]   units_w;
  logic [SEG_W-1:0]    seg_next;
  logic                out_free;

  assign cfg.ready = 1'b1;
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign out_free  = !out_valid || result.ready;

  // duty = (100*mean + 511) / 1023, via x*1025 >> 20 and one correction
  assign x_next   = 17'(q_entry.mean * 17'd100) + 17'd511;
  assign x_rcp    = {x, 10'b0} + 27'(x);
  assign dq_mul   = {dq, 10'b0} - 17'(dq);
  assign dq_rem   = x - dq_mul;
  assign duty_fix = dq + DUTY_W'(dq_rem >= 17'd1023);

  // compare = ((period+1)*duty + 50) / 100
  assign counts  = 17'(period) + 17'd1;
  assign y_prod  = counts * duty_value;
  assign c_prod  = y * CMP_RECIP;
  assign cq_mul  = 23'(cq) * 23'd100;
  assign cq_rem  = y - cq_mul;
  assign cmp_fix = cq + CMP_W'(cq_rem >= 23'd100);

  // tens by *205 >> 11, exact below 100
  assign tens_prod = duty_value * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = {3'b000, tens} * 7'd10;
  assign units_w   = duty_value - tens_x10;

  always_comb begin
    priority if (!is_tick) begin
      seg_next = SEG_BLANK;
    end else if (duty_value == DUTY_FULL) begin
      seg_next = SEG_FULL;
    end else if (!digit_phase) begin
      seg_next = seg_digit(tens);
    end else begin
      seg_next = seg_digit(units_w[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      period      <= PERIOD_RESET;
      duty_value  <= DUTY_RESET;
      digit_phase <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        period <= cfg.data;
      end
      // in S_CMP_FIX the result register is reloaded below
      if (out_valid && result.ready && state != S_CMP_FIX) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            is_tick <= q_entry.is_tick;
            x       <= x_next;
            if (q_entry.is_tick) begin
              digit_phase <= !digit_phase;
              state       <= S_CMP_MUL;
            end else begin
              state <= S_DUTY_EST;
            end
          end
        end
        S_DUTY_EST: begin
          dq    <= x_rcp[26:20];
          state <= S_DUTY_FIX;
        end
        S_DUTY_FIX: begin
          duty_value <= duty_fix;
          state      <= S_CMP_MUL;
        end
        S_CMP_MUL: begin
          y     <= y_prod[22:0] + 23'd50;
          state <= S_CMP_EST;
        end
        S_CMP_EST: begin
          cq    <= c_prod[45:29];
          state <= S_CMP_FIX;
        end
        S_CMP_FIX: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_duty  <= duty_value;
            out_cmp   <= cmp_fix;
            out_high  <= is_tick && !digit_phase;
            out_seg   <= seg_next;
            out_full  <= (duty_value == DUTY_FULL);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.duty_percent  = out_duty;
  assign result.compare_value = out_cmp;
  assign result.high_digit_on = out_high;
  assign result.segments      = out_seg;
  assign result.full_led      = out_full;

`ifndef SYNTHESIS
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    duty_value <= DUTY_FULL)
    else $error("duty above full scale");

  a_duty_fix: assert property (@(posedge clk) disable iff (rst)
    state == S_DUTY_FIX |-> dq_rem < 17'd2046)
    else $error("duty estimate off by more than one");

  a_cmp_fix: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP_FIX |-> cq_rem < 23'd200)
    else $error("compare estimate off by more than one");

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE)
    else $error("sequencer idle after taking an item");
`endif

endmodule

### rtl/adc_average_to_pwm_duty_display_top.sv
// Top level: ADC average to PWM duty with two-digit display drive.
//
// Channels: item (opcode + four 10-bit samples), result (duty, compare value,
// digit select, segments, full LED) and cfg (PWM period minus one, 16 bits).
// Every item yields exactly one result beat, in order.
// A conversion item passes the back end sequencer states S_IDLE (take it
// from the queue), S_DUTY_EST and S_DUTY_FIX (duty division by 1023), then
// S_CMP_MUL, S_CMP_EST and S_CMP_FIX (compare value); a tick item skips the
// duty steps. The sequencer handles one item at a time and takes the next
// only after S_CMP_FIX has loaded the result register. When the sequencer is
// idle, the item lands in a two-entry queue at its beat and is taken in the
// cycle that follows.
// Reset (rst, synchronous) sets period 19999, duty 50, units digit next, and
// empties queue and result register. cfg.ready is always high; write the
// period only while no item is in flight.
// If the receiver stalls, the result register holds; the sequencer finishes
// its item and waits, and the queue keeps taking items until it is full.
module adc_average_to_pwm_duty_display_top import adcpwm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  adcpwm_in_if.sink    item,
  adcpwm_cfg_if.sink   cfg,
  adcpwm_out_if.source result
);

  q_entry_t push_entry;
  q_entry_t pop_entry;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  adcpwm_front u_front (
    .item    (item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  adcpwm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  adcpwm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_entry (pop_entry),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule
